FILE: src/mtep_pkg.sv
// shared types, codes and helpers of the midi track event parser
package mtep_pkg;

   localparam int unsigned LenWidth   = 28;
   localparam int unsigned TempoWidth = 24;
   localparam int unsigned StoreDepth = 3;

   localparam logic [LenWidth-1:0] LenMax = {LenWidth{1'b1}};

   localparam logic [7:0] StatusMeta     = 8'hFF;
   localparam logic [7:0] StatusSysex    = 8'hF0;
   localparam logic [7:0] StatusSysexEnd = 8'hF7;
   localparam logic [7:0] MetaTempo      = 8'h51;
   localparam logic [7:0] MetaEndTrack   = 8'h2F;

   // parse phases, one-hot
   typedef enum logic [5:0] {
      PH_DELTA   = 6'b000001,
      PH_STATUS  = 6'b000010,
      PH_MTYPE   = 6'b000100,
      PH_MLEN    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_SYSEX   = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHANNEL = 2'd0,
      KIND_META    = 2'd1,
      KIND_SYSEX   = 2'd2,
      KIND_BAD     = 2'd3
   } kind_type;

   typedef struct packed {
      phase_type             phase;
      logic [LenWidth-1:0]   vlq_acc;
      logic [LenWidth-1:0]   held_delta;
      logic [7:0]            held_status;
      logic [7:0]            running_status;
      logic [7:0]            held_meta_type;
      logic [LenWidth-1:0]   bytes_remaining;
      logic [LenWidth-1:0]   bytes_taken;
      logic [7:0]            payload0;
      logic [7:0]            payload1;
      logic [7:0]            payload2;
      logic [TempoWidth-1:0] tempo;
      logic                  tempo_captured;
   } parse_state_type;

   typedef struct packed {
      kind_type              event_kind;
      logic [LenWidth-1:0]   delta_ticks;
      logic [7:0]            status_value;
      logic [7:0]            meta_type;
      logic [LenWidth-1:0]   payload_length;
      logic [7:0]            payload_first;
      logic [7:0]            payload_second;
      logic [7:0]            payload_third;
      logic                  track_ended;
      logic [TempoWidth-1:0] tempo_micros;
      logic                  tempo_known;
   } event_type;

   // data bytes of a channel message: program change and channel pressure carry one
   function automatic logic [1:0] chan_count(logic [7:0] status);
      unique case (status[6:4])
         3'd4, 3'd5: chan_count = 2'd1;
         default:    chan_count = 2'd2;
      endcase
   endfunction

endpackage

FILE: src/mtep_step.sv
// next-state and event decode for one track byte
module mtep_step
   import mtep_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      track_byte,
   input  logic            new_track,
   output parse_state_type nxt_state,
   output logic            emit,
   output event_type       evt
);

   function automatic parse_state_type take_byte(parse_state_type st, logic [7:0] b);
      parse_state_type r;
      r = st;
      unique case (st.bytes_taken)
         LenWidth'(0): r.payload0 = b;
         LenWidth'(1): r.payload1 = b;
         LenWidth'(2): r.payload2 = b;
         default: ;
      endcase
      if (st.bytes_taken != LenMax) r.bytes_taken = st.bytes_taken + LenWidth'(1);
      return r;
   endfunction

   parse_state_type     s;
   kind_type            kind;
   logic [7:0]          stat;
   logic [7:0]          mtype;
   logic [LenWidth-1:0] len;
   logic                ended;
   logic                fin_meta;
   logic [LenWidth-1:0] acc_shift;

   always_comb begin
      s        = cur_state;
      emit     = 1'b0;
      fin_meta = 1'b0;
      kind     = KIND_CHANNEL;
      stat     = '0;
      mtype    = '0;
      len      = '0;
      ended    = 1'b0;
      if (new_track) begin
         s.phase          = PH_DELTA;
         s.vlq_acc        = '0;
         s.running_status = '0;
      end
      acc_shift = {s.vlq_acc[LenWidth-8:0], track_byte[6:0]};
      unique case (s.phase)
         PH_DELTA, PH_MLEN: begin
            s.vlq_acc = acc_shift;
            if (!track_byte[7]) begin
               s.vlq_acc = '0;
               if (s.phase == PH_DELTA) begin
                  s.held_delta = acc_shift;
                  s.phase      = PH_STATUS;
               end else begin
                  s.bytes_remaining = acc_shift;
                  if (acc_shift == '0) fin_meta = 1'b1;
                  else s.phase = PH_PAYLOAD;
               end
            end
         end
         PH_STATUS: begin
            s.payload0        = '0;
            s.payload1        = '0;
            s.payload2        = '0;
            s.bytes_taken     = '0;
            s.bytes_remaining = '0;
            s.held_meta_type  = '0;
            priority if (track_byte == StatusMeta) begin
               s.held_status = StatusMeta;
               s.phase       = PH_MTYPE;
            end else if (track_byte == StatusSysex) begin
               s.held_status = StatusSysex;
               s.phase       = PH_SYSEX;
            end else if (track_byte > StatusSysex) begin
               emit = 1'b1;
               kind = KIND_BAD;
               stat = track_byte;
            end else if (track_byte[7]) begin
               s.held_status     = {track_byte[7:4], 4'h0};
               s.running_status  = {track_byte[7:4], 4'h0};
               s.bytes_remaining = LenWidth'(chan_count(track_byte));
               s.phase           = PH_PAYLOAD;
            end else if (s.running_status == '0) begin
               // data byte with no running status to reuse
               emit = 1'b1;
               kind = KIND_BAD;
               stat = track_byte;
            end else begin
               s.held_status     = s.running_status;
               s = take_byte(s, track_byte);
               s.bytes_remaining = LenWidth'(chan_count(s.held_status) - 2'd1);
               if (s.bytes_remaining == '0) begin
                  emit = 1'b1;
                  kind = KIND_CHANNEL;
                  stat = s.held_status;
                  len  = s.bytes_taken;
               end else begin
                  s.phase = PH_PAYLOAD;
               end
            end
         end
         PH_MTYPE: begin
            s.held_meta_type = track_byte;
            s.vlq_acc        = '0;
            s.phase          = PH_MLEN;
         end
         PH_PAYLOAD: begin
            s = take_byte(s, track_byte);
            if (s.bytes_remaining != '0) s.bytes_remaining = s.bytes_remaining - LenWidth'(1);
            if (s.bytes_remaining == '0) begin
               if (s.held_status == StatusMeta) begin
                  fin_meta = 1'b1;
               end else begin
                  emit = 1'b1;
                  kind = KIND_CHANNEL;
                  stat = s.held_status;
                  len  = s.bytes_taken;
               end
            end
         end
         PH_SYSEX: begin
            if (track_byte == StatusSysexEnd) begin
               emit = 1'b1;
               kind = KIND_SYSEX;
               stat = StatusSysex;
               len  = s.bytes_taken;
            end else begin
               s = take_byte(s, track_byte);
            end
         end
         default: s.phase = PH_DELTA;
      endcase
      if (fin_meta) begin
         if (s.held_meta_type == MetaTempo && !s.tempo_captured) begin
            s.tempo          = {s.payload0, s.payload1, s.payload2};
            s.tempo_captured = 1'b1;
         end
         emit  = 1'b1;
         kind  = KIND_META;
         stat  = StatusMeta;
         mtype = s.held_meta_type;
         len   = s.bytes_taken;
         ended = (s.held_meta_type == MetaEndTrack);
      end
      if (emit) s.phase = PH_DELTA;
      nxt_state = s;
      evt.event_kind     = kind;
      evt.delta_ticks    = s.held_delta;
      evt.status_value   = stat;
      evt.meta_type      = mtype;
      evt.payload_length = len;
      evt.payload_first  = s.payload0;
      evt.payload_second = s.payload1;
      evt.payload_third  = s.payload2;
      evt.track_ended    = ended;
      evt.tempo_micros   = s.tempo;
      evt.tempo_known    = s.tempo_captured;
   end

endmodule

FILE: src/mtep_out_buf.sv
// two-entry output register with skid stage for parsed events
module mtep_out_buf
   import mtep_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_data,
   output logic      push_ready,
   output logic      out_valid,
   input  logic      out_ready,
   output event_type out_data
);

   logic      main_valid_ff, main_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   event_type main_ff, main_in;
   event_type skid_ff, skid_in;
   logic      pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: src/midi_track_event_parser.sv
// midi track event parser top level
// Takes the bytes of a track chunk one per transaction and returns one event
// transaction for every completed event: delta time, status, meta type, payload
// length, first three payload bytes, end-of-track flag and the first tempo seen.
// Raise req_new_track with the first byte of each track to drop running status
// and restart at a delta time; the captured tempo survives. A byte is taken every
// cycle: the parse state is updated in the same cycle the byte is accepted and an
// event lands in a two-entry output register, so req_ready only drops while both
// entries hold events the consumer has not yet taken. Each event is registered
// in the output buffer ahead of rsp_valid. Bad status bytes (0xF1..0xFE) and
// data bytes with no running status come back as kind 3 and parsing resyncs.
module midi_track_event_parser
   import mtep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_track_byte,
   input  logic                  req_new_track,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_event_kind,
   output logic [LenWidth-1:0]   rsp_delta_ticks,
   output logic [7:0]            rsp_status_value,
   output logic [7:0]            rsp_meta_type,
   output logic [LenWidth-1:0]   rsp_payload_length,
   output logic [7:0]            rsp_payload_first,
   output logic [7:0]            rsp_payload_second,
   output logic [7:0]            rsp_payload_third,
   output logic                  rsp_track_ended,
   output logic [TempoWidth-1:0] rsp_tempo_micros,
   output logic                  rsp_tempo_known
);

   // parse state registers
   parse_state_type state_ff, state_in;
   parse_state_type step_state;
   logic            step_emit;
   event_type       step_evt;
   event_type       out_evt;
   logic            accept;

   // one byte of decode per accepted transaction
   mtep_step u_step (
      .cur_state (state_ff),
      .track_byte(req_track_byte),
      .new_track (req_new_track),
      .nxt_state (step_state),
      .emit      (step_emit),
      .evt       (step_evt)
   );

   assign accept   = req_valid && req_ready;
   assign state_in = accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_DELTA;
         state_ff.vlq_acc        <= '0;
         state_ff.held_delta     <= '0;
         state_ff.held_status    <= '0;
         state_ff.running_status <= '0;
         state_ff.held_meta_type <= '0;
         state_ff.bytes_remaining <= '0;
         state_ff.bytes_taken    <= '0;
         state_ff.payload0       <= '0;
         state_ff.payload1       <= '0;
         state_ff.payload2       <= '0;
         state_ff.tempo          <= '0;
         state_ff.tempo_captured <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register plus skid entry, keeps input flowing while the consumer stalls
   mtep_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && step_emit),
      .push_data (step_evt),
      .push_ready(req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_evt)
   );

   assign rsp_event_kind     = out_evt.event_kind;
   assign rsp_delta_ticks    = out_evt.delta_ticks;
   assign rsp_status_value   = out_evt.status_value;
   assign rsp_meta_type      = out_evt.meta_type;
   assign rsp_payload_length = out_evt.payload_length;
   assign rsp_payload_first  = out_evt.payload_first;
   assign rsp_payload_second = out_evt.payload_second;
   assign rsp_payload_third  = out_evt.payload_third;
   assign rsp_track_ended    = out_evt.track_ended;
   assign rsp_tempo_micros   = out_evt.tempo_micros;
   assign rsp_tempo_known    = out_evt.tempo_known;

endmodule
